FILE: rtl/core/quoted_printable_decoder_top_macros.svh
// assertion macros shared by the decoder modules
`ifndef QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define QPD_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QPD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/qpd_pkg.sv
`default_nettype none

package qpd_pkg;

    // widths and sizes
    localparam int QPD_COUNT_WIDTH = 24;
    localparam int QPD_FIFO_DEPTH  = 4;
    localparam int MAX_LEN_W       = 24;
    localparam int PDATA_W         = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int REG_IDX_W       = APB_ADDR_W - 2;
    localparam int ENTRY_SLOTS     = 3;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = '0;

    // characters
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // escape tracking
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_EQ   = 2'd1,
        PH_HELD = 2'd2
    } qpd_phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } qpd_hex_t;

    // one accepted transaction's worth of results
    typedef struct packed {
        logic [ENTRY_SLOTS-1:0][7:0] data;
        logic [1:0]                  count;
        logic                        has_byte;
        logic                        last;
        logic                        err;
    } qpd_entry_t;

    function automatic qpd_hex_t hex_decode(input logic [7:0] c);
        qpd_hex_t h;
        h.ok  = 1'b0;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qpd_front.sv
`default_nettype none

module qpd_front
    import qpd_pkg::*;
#(
    parameter int COUNT_WIDTH = QPD_COUNT_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_in_byte,
    input  wire logic                 s_end_of_message,
    input  wire logic [MAX_LEN_W-1:0] max_len,
    input  wire logic                 fifo_full,
    output logic                      push,
    output qpd_entry_t                entry
);

`include "quoted_printable_decoder_top_macros.svh"

    localparam int CMP_W = (COUNT_WIDTH > MAX_LEN_W) ? COUNT_WIDTH : MAX_LEN_W;

    qpd_phase_t              phase_reg, phase_next, phase_mid;
    logic [7:0]              held_reg, held_next, held_mid;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic                    over_reg, over_next, over_now;
    logic                    fire;
    qpd_hex_t                hex_b, hex_h;
    logic [1:0]              n;

    assign s_ready = !fifo_full;
    assign fire    = s_valid && s_ready;
    assign hex_b   = hex_decode(s_in_byte);
    assign hex_h   = hex_decode(held_reg);

    // saturating byte count and length check
    assign cnt_inc  = (&cnt_reg) ? cnt_reg : cnt_reg + COUNT_WIDTH'(1);
    assign over_now = over_reg || (CMP_W'(cnt_inc) > CMP_W'(max_len));

    // escape phase next state
    always_comb begin
        phase_mid = PH_IDLE;
        held_mid  = held_reg;
        unique case (phase_reg)
            PH_EQ: begin
                if (hex_b.ok || s_in_byte == CH_CR) begin
                    phase_mid = PH_HELD;
                    held_mid  = s_in_byte;
                end else begin
                    phase_mid = (s_in_byte == CH_EQ) ? PH_EQ : PH_IDLE;
                end
            end
            PH_HELD: begin
                held_mid = 8'h00;
                if (hex_h.ok && hex_b.ok) begin
                    phase_mid = PH_IDLE;
                end else if (held_reg == CH_CR && s_in_byte == CH_LF) begin
                    phase_mid = PH_IDLE;
                end else begin
                    phase_mid = (s_in_byte == CH_EQ) ? PH_EQ : PH_IDLE;
                end
            end
            default: begin
                phase_mid = (s_in_byte == CH_EQ) ? PH_EQ : PH_IDLE;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        over_next  = over_reg;
        if (fire) begin
            if (s_end_of_message) begin
                phase_next = PH_IDLE;
                held_next  = 8'h00;
                cnt_next   = '0;
                over_next  = 1'b0;
            end else begin
                phase_next = phase_mid;
                held_next  = held_mid;
                cnt_next   = cnt_inc;
                over_next  = over_now;
            end
        end
    end

    // result list for this transaction
    always_comb begin
        n              = 2'd0;
        entry.data     = '0;
        entry.has_byte = 1'b1;
        entry.last     = s_end_of_message;
        entry.err      = over_now;
        unique case (phase_reg)
            PH_EQ: begin
                if (!(hex_b.ok || s_in_byte == CH_CR)) begin
                    entry.data[n] = CH_EQ;
                    n = n + 2'd1;
                    if (s_in_byte != CH_EQ) begin
                        entry.data[n] = s_in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            PH_HELD: begin
                if (hex_h.ok && hex_b.ok) begin
                    entry.data[n] = {hex_h.val, hex_b.val};
                    n = n + 2'd1;
                end else if (!(held_reg == CH_CR && s_in_byte == CH_LF)) begin
                    entry.data[n] = CH_EQ;
                    n = n + 2'd1;
                    entry.data[n] = held_reg;
                    n = n + 2'd1;
                    if (s_in_byte != CH_EQ) begin
                        entry.data[n] = s_in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            default: begin
                if (s_in_byte != CH_EQ) begin
                    entry.data[n] = s_in_byte;
                    n = n + 2'd1;
                end
            end
        endcase
        // end of message: flush a pending escape; a bare marker if no result is left
        if (s_end_of_message) begin
            if (phase_mid == PH_EQ) begin
                entry.data[n] = CH_EQ;
                n = n + 2'd1;
            end else if (phase_mid == PH_HELD) begin
                entry.data[n] = CH_EQ;
                n = n + 2'd1;
                entry.data[n] = held_mid;
                n = n + 2'd1;
            end
            if (n == 2'd0) begin
                entry.has_byte = 1'b0;
                n = 2'd1;
            end
        end
        entry.count = n;
    end

    assign push = fire && (n != 2'd0);

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
            cnt_reg   <= '0;
            over_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
            over_reg  <= over_next;
        end
    end

    `QPD_ASSERT_NEXT(a_eom_clears, aclk, aresetn, fire && s_end_of_message,
        cnt_reg == '0 && phase_reg == PH_IDLE && !over_reg, "state not cleared after message end")
    `QPD_ASSERT_IMPL(a_push_nonempty, aclk, aresetn, push,
        entry.count != 2'd0, "empty entry pushed")

endmodule

`default_nettype wire

FILE: rtl/core/qpd_fifo.sv
`default_nettype none

module qpd_fifo
    import qpd_pkg::*;
#(
    parameter int DEPTH = QPD_FIFO_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire qpd_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output qpd_entry_t      head
);

`include "quoted_printable_decoder_top_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qpd_entry_t       slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `QPD_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `QPD_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/qpd_back.sv
`default_nettype none

module qpd_back
    import qpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       head_valid,
    input  wire qpd_entry_t head,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_has_byte,
    output logic            m_last_of_message,
    output logic            m_length_error
);

`include "quoted_printable_decoder_top_macros.svh"

    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg, last_reg, err_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load, final_slot;

    // output register takes a new result when one is queued and it is empty or being taken
    assign load       = head_valid && (!m_valid_reg || m_ready);
    assign final_slot = (idx_reg == head.count - 2'd1);
    assign pop        = load && final_slot;
    assign idx_next   = final_slot ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= idx_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head.has_byte ? head.data[idx_reg] : 8'h00;
            has_reg  <= head.has_byte;
            last_reg <= head.last && final_slot;
            err_reg  <= head.err;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = byte_reg;
    assign m_has_byte        = has_reg;
    assign m_last_of_message = last_reg;
    assign m_length_error    = err_reg;

    `QPD_ASSERT_IMPL(a_idx_in_range, aclk, aresetn, head_valid,
        idx_reg < head.count, "slot index past entry count")

endmodule

`default_nettype wire

FILE: rtl/core/quoted_printable_decoder_top.sv
// channel    | dir | handshake           | payload
// s_ (input) | in  | s_valid / s_ready   | s_in_byte, s_end_of_message
// m_ (result)| out | m_valid / m_ready   | m_out_byte, m_has_byte,
//            |     |                     | m_last_of_message, m_length_error
// apb config | in  | psel/penable/pready | paddr, pwdata, prdata
//
// one input byte per cycle is accepted while s_ready is high; one result per cycle
// is emitted while m_ready is high; a byte that expands into two or three results
// holds the output stage until all are out; the queue between front and back
// absorbs the difference until it fills; reset is synchronous on aresetn and needs
// no clearing pass; items are taken the cycle after reset is released
// s_ready drops only when the queue is full; results wait in the output register
`default_nettype none

module quoted_printable_decoder_top
    import qpd_pkg::*;
#(
    parameter int COUNT_WIDTH = QPD_COUNT_WIDTH,
    parameter int FIFO_DEPTH  = QPD_FIFO_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_in_byte,
    input  wire logic                  s_end_of_message,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_has_byte,
    output logic                       m_last_of_message,
    output logic                       m_length_error,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 fifo_full, push, pop, head_valid;
    qpd_entry_t           push_entry, head;

    // register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && reg_idx == REG_MAX_LEN) begin
            max_len_reg <= pwdata[MAX_LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_MAX_LEN) begin
            prdata = {{(PDATA_W - MAX_LEN_W){1'b0}}, max_len_reg};
        end
    end

    // front: escape tracking and length check
    qpd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .max_len          (max_len_reg),
        .fifo_full        (fifo_full),
        .push             (push),
        .entry            (push_entry)
    );

    // queue between the two sides
    qpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: serializes each entry into results
    qpd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_has_byte        (m_has_byte),
        .m_last_of_message (m_last_of_message),
        .m_length_error    (m_length_error)
    );

endmodule

`default_nettype wire

FILE: bench/quoted_printable_decoder_top_tb.sv
`timescale 1ns / 100ps

module quoted_printable_decoder_top_tb;
    import qpd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;

    // one encoded byte on the input channel
    typedef struct packed {
        logic [7:0] value;
        logic       eom;
    } qp_char_t;

    // one decoded result on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       err;
    } qp_result_t;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_in_byte         = 8'h00;
    logic                  s_end_of_message  = 1'b0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_has_byte;
    logic                  m_last_of_message;
    logic                  m_length_error;
    logic                  psel              = 1'b0;
    logic                  penable           = 1'b0;
    logic                  pwrite            = 1'b0;
    logic [APB_ADDR_W-1:0] paddr             = '0;
    logic [PDATA_W-1:0]    pwdata            = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // decoder state mirror
    qpd_phase_t                 esc_phase = PH_IDLE;
    logic [7:0]                 held      = 8'h00;
    logic [QPD_COUNT_WIDTH-1:0] msg_count = '0;
    logic                       overlong  = 1'b0;
    logic [MAX_LEN_W-1:0]       max_len   = MAX_LEN_RESET;

    qp_char_t   pending_q[$];
    qp_result_t step_q[$];
    qp_result_t decoded_q[$];
    qp_char_t   next_char;
    qp_result_t want;

    logic in_taken     = 1'b0;
    int   in_gap       = 0;
    int   out_gap      = 0;
    int   in_gap_pct   = 0;
    int   out_gap_pct  = 0;
    int   stall_cycles = 0;
    int   errors       = 0;
    int   bytes_in     = 0;
    int   messages_in  = 0;
    int   results_seen = 0;
    int   queued_total = 0;

    quoted_printable_decoder_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_end_of_message  (s_end_of_message),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_has_byte        (m_has_byte),
        .m_last_of_message (m_last_of_message),
        .m_length_error    (m_length_error),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= "9")
            return 4'(c - 8'h30);
        else if (c <= "F")
            return 4'(c - 8'h37);
        else
            return 4'(c - 8'h57);
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        qp_result_t r;
        r = '0;
        r.data = b;
        r.has_byte = 1'b1;
        step_q.push_back(r);
    endfunction

    // byte seen with no escape pending
    function automatic void take_plain(input logic [7:0] c);
        if (c == CH_EQ)
            esc_phase = PH_EQ;
        else
            emit_byte(c);
    endfunction

    // work out the results of one accepted transaction
    function automatic void decode_byte(input logic [7:0] c, input logic eom);
        qp_result_t marker;
        marker = '0;
        if (msg_count != '1)
            msg_count = msg_count + 1'b1;
        if (msg_count > max_len)
            overlong = 1'b1;
        case (esc_phase)
            PH_EQ: begin
                if (is_hex(c) || c == CH_CR) begin
                    held = c;
                    esc_phase = PH_HELD;
                end else begin
                    esc_phase = PH_IDLE;
                    emit_byte(CH_EQ);
                    take_plain(c);
                end
            end
            PH_HELD: begin
                esc_phase = PH_IDLE;
                if (is_hex(held) && is_hex(c)) begin
                    emit_byte({nibble_of(held), nibble_of(c)});
                end else if (!(held == CH_CR && c == CH_LF)) begin
                    emit_byte(CH_EQ);
                    emit_byte(held);
                    take_plain(c);
                end
                held = 8'h00;
            end
            default: begin
                esc_phase = PH_IDLE;
                take_plain(c);
            end
        endcase
        // flush a dangling escape at end of message
        if (eom) begin
            if (esc_phase == PH_EQ) begin
                emit_byte(CH_EQ);
            end else if (esc_phase == PH_HELD) begin
                emit_byte(CH_EQ);
                emit_byte(held);
            end
            if (step_q.size() == 0)
                step_q.push_back(marker);
            step_q[step_q.size() - 1].last = 1'b1;
        end
        foreach (step_q[i]) begin
            step_q[i].err = overlong;
            decoded_q.push_back(step_q[i]);
        end
        step_q.delete();
        if (eom) begin
            esc_phase = PH_IDLE;
            held = 8'h00;
            msg_count = '0;
            overlong = 1'b0;
        end
    endfunction

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_q.size() > 0 && in_gap_pct > 0
                         && $urandom_range(0, 99) < in_gap_pct) begin
                s_valid <= 1'b0;
                in_gap <= $urandom_range(0, 17);
            end else if (pending_q.size() > 0) begin
                next_char = pending_q.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= next_char.value;
                s_end_of_message <= next_char.eom;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            m_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else if (out_gap_pct > 0 && $urandom_range(0, 99) < out_gap_pct) begin
            m_ready <= 1'b0;
            out_gap <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, s_end_of_message);
                bytes_in++;
                if (s_end_of_message)
                    messages_in++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%b/%b/%b",
                             $time, m_out_byte, m_has_byte, m_last_of_message,
                             m_length_error);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.data, m_out_byte);
                    check_field("has_byte", 8'(want.has_byte), 8'(m_has_byte));
                    check_field("last_of_message", 8'(want.last), 8'(m_last_of_message));
                    check_field("length_error", 8'(want.err), 8'(m_length_error));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic void push_char(input logic [7:0] v, input logic eom);
        qp_char_t ch;
        ch.value = v;
        ch.eom = eom;
        pending_q.push_back(ch);
        queued_total++;
    endfunction

    function automatic void queue_chars(input string s, input bit eom);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i], eom && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10)
            return 8'(8'h30 + nib);
        else if ($urandom_range(0, 1) != 0)
            return 8'(8'h41 + nib - 10);
        else
            return 8'(8'h61 + nib - 10);
    endfunction

    // one message built from random bytes and well-formed escapes, plus some noise
    function automatic void queue_message(input int tokens);
        logic [7:0] msg[$];
        int t;
        int pick;
        for (t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 75) begin
                msg.push_back(CH_EQ);
                msg.push_back(hex_char(4'($urandom)));
                msg.push_back(hex_char(4'($urandom)));
            end else if (pick < 83) begin
                msg.push_back(CH_EQ);
                msg.push_back(CH_CR);
                msg.push_back(CH_LF);
            end else if (pick < 88) begin
                msg.push_back(CH_EQ);
                msg.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                msg.push_back(CH_EQ);
                msg.push_back(($urandom_range(0, 1) != 0) ? CH_CR : hex_char(4'($urandom)));
                msg.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg.push_back(CH_EQ);
            end
        end
        foreach (msg[i])
            push_char(msg[i], i == msg.size() - 1);
    endfunction

    function automatic void queue_random(input int nbytes);
        int start;
        start = queued_total;
        while (queued_total - start < nbytes)
            queue_message($urandom_range(1, 8));
    endfunction

    // wait until everything sent has been decoded and the block has gone quiet
    task automatic settle();
        while (pending_q.size() > 0 || s_valid || decoded_q.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [MAX_LEN_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_LEN, 2'b00};
        pwdata <= {{(PDATA_W - MAX_LEN_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        max_len = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic new_setting(input logic [MAX_LEN_W-1:0] limit, input int ipct,
                               input int opct);
        settle();
        write_max_len(limit);
        in_gap_pct = ipct;
        out_gap_pct = opct;
    endtask

    // stimulus
    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: byte extremes, escapes, soft breaks, malformed and flushed escapes
        new_setting(MAX_LEN_RESET, 20, 20);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        queue_chars("=fF", 1'b0);
        push_char(CH_EQ, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        queue_chars("=G=4Z==3D", 1'b1);
        queue_chars("=", 1'b1);
        queue_chars("=9", 1'b1);
        // soft break closing a message leaves only the end marker
        push_char(CH_EQ, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b1);
        queue_chars("=4=", 1'b1);

        // random messages under several length limits
        new_setting(24'd1, 25, 25);
        queue_random(28);
        new_setting(24'd0, 0, 40);
        queue_random(28);
        new_setting(24'd6, 40, 0);
        queue_random(28);
        new_setting(24'($urandom_range(2, 15)), 15, 15);
        queue_random(28);
        new_setting(MAX_LEN_RESET, 0, 0);
        queue_random(28);

        settle();
        $display("covered %0d bytes in %0d messages, %0d results checked",
                 bytes_in, messages_in, results_seen);
        $display("limits 0, 1, 6, a random one and the reset value, with and without stalls");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
